// ===== rtl/core/bfs_pkg.sv =====
`default_nettype none

package bfs_pkg;

  // Graph size and field widths
  localparam int MAX_NODES   = 64;
  localparam int NODE_W      = 6;
  localparam int CNT_W       = 7;
  localparam int ROW_W       = 64;

  // Neighbor scan works on one chunk of the fresh mask at a time, staying on a chunk while it has pending neighbors
  localparam int CHUNK_W     = 8;
  localparam int CHUNK_SEL_W = 3;
  localparam int OFFS_W      = 3;

  // Action codes of an input transaction
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Reset value of the node count register
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(MAX_NODES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAD,
    ST_POP,
    ST_ROW,
    ST_FRESH,
    ST_SCAN,
    ST_EMIT
  } bfs_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_row;
    logic start_trav;
    logic pop;
    logic row_rd;
    logic fresh_ld;
    logic scan;
    logic out_node;
    logic out_bad;
  } bfs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_bad;
    logic chunk_hit;
    logic chunk_last;
    logic queue_empty;
    logic out_free;
  } bfs_stat_t;

  // Position of the lowest set bit of a chunk
  function automatic logic [OFFS_W-1:0] lowest_set(input logic [CHUNK_W-1:0] bits);
    logic [OFFS_W-1:0] idx;
    idx = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = OFFS_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bfs_ctrl.sv =====
`default_nettype none

module bfs_ctrl
  import bfs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_action,
  input  wire bfs_stat_t stat,
  output bfs_cmd_t       cmd,
  output logic           in_stall
);

  bfs_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_START) begin
          state_nxt = stat.start_bad ? ST_BAD : ST_POP;
        end
      end
      ST_BAD: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_POP:   state_nxt = ST_ROW;
      ST_ROW:   state_nxt = ST_FRESH;
      ST_FRESH: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (!stat.chunk_hit && stat.chunk_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) state_nxt = stat.queue_empty ? ST_IDLE : ST_POP;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.load_row   = in_valid && in_action == ACT_LOAD;
        cmd.start_trav = in_valid && in_action == ACT_START && !stat.start_bad;
      end
      ST_BAD:   cmd.out_bad  = stat.out_free;
      ST_POP:   cmd.pop      = 1'b1;
      ST_ROW:   cmd.row_rd   = 1'b1;
      ST_FRESH: cmd.fresh_ld = 1'b1;
      ST_SCAN:  cmd.scan     = 1'b1;
      ST_EMIT:  cmd.out_node = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/bfs_dp.sv =====
`default_nettype none

module bfs_dp
  import bfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,
  input  wire logic [NODE_W-1:0] in_row_index,
  input  wire logic [ROW_W-1:0]  in_row_bits,
  input  wire logic [NODE_W-1:0] in_start_node,
  input  wire logic              out_stall,
  input  wire bfs_cmd_t          cmd,
  output bfs_stat_t              stat,
  output logic                   out_valid,
  output logic [NODE_W-1:0]      out_visited_node,
  output logic                   out_last,
  output logic                   out_bad_start
);

  logic [CNT_W-1:0]       node_count_r;
  logic [CNT_W-1:0]       n_eff;
  logic [ROW_W-1:0]       in_use;

  logic [ROW_W-1:0]       adj_mem_r [MAX_NODES];
  logic [ROW_W-1:0]       adj_rd_r;
  logic [NODE_W-1:0]      queue_mem_r [MAX_NODES];
  logic [NODE_W-1:0]      q_rd_r;
  logic [CNT_W-1:0]       head_r;
  logic [CNT_W-1:0]       tail_r;
  logic [ROW_W-1:0]       visited_r;
  logic [ROW_W-1:0]       fresh_r;
  logic [CHUNK_SEL_W-1:0] chunk_r;
  logic [NODE_W-1:0]      cur_r;

  logic [CHUNK_W-1:0]     chunk_bits;
  logic [OFFS_W-1:0]      hit_offs;
  logic [NODE_W-1:0]      hit_node;
  logic                   push;
  logic                   q_wr_en;
  logic [NODE_W-1:0]      q_wr_addr;
  logic [NODE_W-1:0]      q_wr_data;

  logic                   out_valid_r;
  logic [NODE_W-1:0]      out_node_r;
  logic                   out_last_r;
  logic                   out_bad_r;

  // Node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  // Clamp count to 1..MAX_NODES and build the in-use mask
  always_comb begin
    priority if (node_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count_r > CNT_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
    for (int i = 0; i < ROW_W; i++) begin
      in_use[i] = CNT_W'(i) < n_eff;
    end
  end

  // Current scan chunk and its lowest pending neighbor
  assign chunk_bits = fresh_r[chunk_r * CHUNK_W +: CHUNK_W];
  assign hit_offs   = lowest_set(chunk_bits);
  assign hit_node   = {chunk_r, hit_offs};
  assign push       = cmd.scan && (chunk_bits != '0);

  // Adjacency memory
  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      adj_mem_r[in_row_index] <= in_row_bits;
    end
    if (cmd.row_rd) begin
      adj_rd_r <= adj_mem_r[q_rd_r];
    end
  end

  // Queue memory: start node at slot 0, neighbors at the tail
  always_comb begin
    q_wr_en   = cmd.start_trav || push;
    q_wr_addr = cmd.start_trav ? '0 : tail_r[NODE_W-1:0];
    q_wr_data = cmd.start_trav ? in_start_node : hit_node;
  end

  always_ff @(posedge clk) begin
    if (q_wr_en) begin
      queue_mem_r[q_wr_addr] <= q_wr_data;
    end
    if (cmd.pop) begin
      q_rd_r <= queue_mem_r[head_r[NODE_W-1:0]];
    end
  end

  // Queue pointers and visited mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      visited_r <= '0;
    end else if (cmd.start_trav) begin
      head_r    <= '0;
      tail_r    <= CNT_W'(1);
      visited_r <= ROW_W'(1) << in_start_node;
    end else begin
      if (cmd.pop) head_r <= head_r + CNT_W'(1);
      if (push) begin
        tail_r              <= tail_r + CNT_W'(1);
        visited_r[hit_node] <= 1'b1;
      end
    end
  end

  // Scan state: current node, fresh mask, chunk pointer
  always_ff @(posedge clk) begin
    if (cmd.row_rd) begin
      cur_r <= q_rd_r;
    end
    if (cmd.fresh_ld) begin
      fresh_r <= adj_rd_r & in_use & ~visited_r;
    end else if (push) begin
      fresh_r[hit_node] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
    end else if (cmd.fresh_ld) begin
      chunk_r <= '0;
    end else if (cmd.scan && !push) begin
      chunk_r <= chunk_r + CHUNK_SEL_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_node || cmd.out_bad) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_node) begin
      out_node_r <= cur_r;
      out_last_r <= head_r == tail_r;
      out_bad_r  <= 1'b0;
    end else if (cmd.out_bad) begin
      out_node_r <= '0;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
    end
  end

  // Status to the controller
  always_comb begin
    stat.start_bad   = {1'b0, in_start_node} >= n_eff;
    stat.chunk_hit   = chunk_bits != '0;
    stat.chunk_last  = chunk_r == '1;
    stat.queue_empty = head_r == tail_r;
    stat.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_visited_node = out_node_r;
  assign out_last         = out_last_r;
  assign out_bad_start    = out_bad_r;

endmodule

`default_nettype wire

// ===== rtl/core/bfs_adjacency_matrix_unit.sv =====
// Breadth-first traversal over a 64-node adjacency matrix.
// Input channel (in_valid / in_stall): in_action = load writes row in_row_index
// with in_row_bits and gives no result; in_action = start begins a traversal
// at in_start_node. Result channel (out_valid / out_stall): one transaction per
// visited node in breadth-first order, out_last set on the final one. A start
// node not below the node count gives a single transaction with out_bad_start
// and out_last set and out_visited_node zero.
// cfg_wr_en / cfg_wr_data write the node count (0 acts as 1, above 64 as 64);
// write it only while no traversal is running.
// Loads are taken only while idle. A traversal is worked off one node at a
// time by the controller: queue read, row read, mask setup, a scan of the
// eight chunks that stays on a chunk for each enqueued neighbor, then emit.
// The scan is bounded by the single-port queue write.
// in_stall is high from a start until its last result is loaded. A stalled
// result holds in the output register and the traversal waits at its next
// emit. Synchronous reset clears the control, pointers and visited mask and
// sets the node count to 64; matrix rows are undefined until loaded.
`default_nettype none

module bfs_adjacency_matrix_unit
  import bfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_action,
  input  wire logic [NODE_W-1:0] in_row_index,
  input  wire logic [ROW_W-1:0]  in_row_bits,
  input  wire logic [NODE_W-1:0] in_start_node,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [NODE_W-1:0]      out_visited_node,
  output logic                   out_last,
  output logic                   out_bad_start
);

  bfs_cmd_t  cmd;
  bfs_stat_t stat;

  bfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  bfs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_row_index     (in_row_index),
    .in_row_bits      (in_row_bits),
    .in_start_node    (in_start_node),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_visited_node (out_visited_node),
    .out_last         (out_last),
    .out_bad_start    (out_bad_start)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bfs_checker.sv =====
`default_nettype none

module bfs_checker
  import bfs_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              in_action,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [NODE_W-1:0] out_visited_node,
  input wire logic              out_last,
  input wire logic              out_bad_start
);

  // No result transaction pending right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_visited_node)
      && $stable(out_last) && $stable(out_bad_start))
    else $error("stalled result changed");

  // Error result is a lone, final transaction with node zero
  a_bad_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_start |-> out_last && out_visited_node == '0)
    else $error("malformed bad start result");

  // An accepted start blocks the input channel in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_START |=> in_stall)
    else $error("input accepted during traversal");

endmodule

bind bfs_adjacency_matrix_unit bfs_checker u_bfs_checker (.*);

`default_nettype wire
